### design/itgp_pkg.sv
// itgp_pkg: types, widths and arithmetic helpers for image_to_ground_plane.
// No dependencies; used by itgp_front, itgp_div_step and the top level.
package itgp_pkg;

    // width of one 2x2 system entry, sized for the widest pixel fraction
    localparam int AW = 49;
    // width of one exact product of two entries
    localparam int PW = 2 * AW;
    // width of a determinant or a Cramer numerator before scaling
    localparam int DW = PW + 1;
    // quotient bits produced by the divider
    localparam int QW = 32;
    // split point for the partial products
    localparam int SPL = 24;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ROW0_XY    = 3'd0;
    localparam logic [2:0] REG_ROW1_XY    = 3'd1;
    localparam logic [2:0] REG_ROW2_XY    = 3'd2;
    localparam logic [2:0] REG_OFFSETS_01 = 3'd3;
    localparam logic [2:0] REG_OFFSET_2   = 3'd4;

    // four partial products of one AW x AW signed multiply
    typedef struct packed {
        logic signed [2*(AW-SPL)-1:0] hh;
        logic signed [AW+1-1:0]       hl;
        logic signed [AW+1-1:0]       lh;
        logic [2*SPL-1:0]             ll;
    } pp_t;

    // state of one restoring division in flight
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] nlow;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
    } div_t;

    typedef struct packed {
        logic [QW-1:0] value;
        logic          sat;
    } quo_t;

    function automatic pp_t split_mul(logic signed [AW-1:0] x, logic signed [AW-1:0] y);
        logic signed [AW-SPL-1:0] xh;
        logic signed [AW-SPL-1:0] yh;
        logic [SPL-1:0]           xl;
        logic [SPL-1:0]           yl;
        pp_t                      r;
        xh = x[AW-1:SPL];
        yh = y[AW-1:SPL];
        xl = x[SPL-1:0];
        yl = y[SPL-1:0];
        r.hh = xh * yh;
        r.hl = xh * $signed({1'b0, yl});
        r.lh = $signed({1'b0, xl}) * yh;
        r.ll = xl * yl;
        return r;
    endfunction

    function automatic logic signed [PW-1:0] join_mul(pp_t p);
        logic signed [PW-1:0] hh;
        logic signed [PW-1:0] hl;
        logic signed [PW-1:0] lh;
        logic signed [PW-1:0] ll;
        hh = PW'($signed(p.hh));
        hl = PW'($signed(p.hl));
        lh = PW'($signed(p.lh));
        ll = $signed({{(PW-2*SPL){1'b0}}, p.ll});
        return (hh <<< (2*SPL)) + (hl <<< SPL) + (lh <<< SPL) + ll;
    endfunction

    // sign, saturation and truncation of a finished quotient
    function automatic quo_t finish_quo(div_t d);
        quo_t r;
        if (d.neg) begin
            if (d.ovf || d.quo > 32'h8000_0000) begin
                r.value = 32'h8000_0000;
                r.sat   = 1'b1;
            end else begin
                r.value = 32'd0 - d.quo;
                r.sat   = 1'b0;
            end
        end else begin
            if (d.ovf || d.quo[QW-1]) begin
                r.value = 32'h7FFF_FFFF;
                r.sat   = 1'b1;
            end else begin
                r.value = d.quo;
                r.sat   = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

### design/itgp_front.sv
// itgp_front: six-stage front end: system entries, Cramer products,
// magnitudes, overflow check and divider seed. Depends on itgp_pkg.
module itgp_front #(
    parameter int COEF_FRAC_BITS  = 16,
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [15:0]              pixel_u,
    input  logic [15:0]              pixel_v,
    input  logic signed [31:0]       m00,
    input  logic signed [31:0]       m01,
    input  logic signed [31:0]       m03,
    input  logic signed [31:0]       m10,
    input  logic signed [31:0]       m11,
    input  logic signed [31:0]       m13,
    input  logic signed [31:0]       m20,
    input  logic signed [31:0]       m21,
    input  logic signed [31:0]       m23,
    output logic                     out_valid,
    output itgp_pkg::div_t           div_x,
    output itgp_pkg::div_t           div_y,
    output logic [itgp_pkg::DW-1:0]  dmag,
    output logic                     det_zero
);

    localparam int AW = itgp_pkg::AW;
    localparam int PW = itgp_pkg::PW;
    localparam int DW = itgp_pkg::DW;
    localparam int QW = itgp_pkg::QW;
    localparam int NW = DW + COEF_FRAC_BITS;
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    // pm - cs, or cs - pm when flip is set
    function automatic logic signed [AW-1:0] lin(logic [15:0] p, logic signed [31:0] m,
                                                 logic signed [31:0] c, logic flip);
        logic signed [AW-1:0] pm;
        logic signed [AW-1:0] cs;
        pm = $signed({1'b0, p}) * m;
        cs = AW'(c) <<< PIXEL_FRAC_BITS;
        return flip ? (cs - pm) : (pm - cs);
    endfunction

    logic [5:0] vld_reg;

    logic signed [AW-1:0] a11_reg, a12_reg, b1_reg, a21_reg, a22_reg, b2_reg;
    itgp_pkg::pp_t        pp_reg [0:5];
    logic signed [PW-1:0] prod_reg [0:5];
    logic signed [DW-1:0] det_reg, nx_reg, ny_reg;
    logic [DW-1:0]        dmag_reg, nxm_reg, nym_reg;
    logic                 negx_reg, negy_reg, dz5_reg;
    itgp_pkg::div_t       divx_reg, divy_reg;
    logic [DW-1:0]        dmag6_reg;
    logic                 dz6_reg;

    logic [NW-1:0] nxs, nys;
    logic [CW-1:0] dsh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a11_reg <= lin(pixel_u, m20, m00, 1'b0);
            a12_reg <= lin(pixel_u, m21, m01, 1'b0);
            b1_reg  <= lin(pixel_u, m23, m03, 1'b1);
            a21_reg <= lin(pixel_v, m20, m10, 1'b0);
            a22_reg <= lin(pixel_v, m21, m11, 1'b0);
            b2_reg  <= lin(pixel_v, m23, m13, 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0] <= itgp_pkg::split_mul(a11_reg, a22_reg);
            pp_reg[1] <= itgp_pkg::split_mul(a12_reg, a21_reg);
            pp_reg[2] <= itgp_pkg::split_mul(b1_reg, a22_reg);
            pp_reg[3] <= itgp_pkg::split_mul(a12_reg, b2_reg);
            pp_reg[4] <= itgp_pkg::split_mul(a11_reg, b2_reg);
            pp_reg[5] <= itgp_pkg::split_mul(b1_reg, a21_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                prod_reg[i] <= itgp_pkg::join_mul(pp_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= DW'(prod_reg[0]) - DW'(prod_reg[1]);
            nx_reg  <= DW'(prod_reg[2]) - DW'(prod_reg[3]);
            ny_reg  <= DW'(prod_reg[4]) - DW'(prod_reg[5]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            nxm_reg  <= nx_reg[DW-1] ? DW'(-nx_reg) : DW'(nx_reg);
            nym_reg  <= ny_reg[DW-1] ? DW'(-ny_reg) : DW'(ny_reg);
            negx_reg <= nx_reg[DW-1] ^ det_reg[DW-1];
            negy_reg <= ny_reg[DW-1] ^ det_reg[DW-1];
            dz5_reg  <= (det_reg == '0);
        end
    end

    // numerators carry the coefficient scaling; overflow when n >= d * 2^32
    assign nxs = {nxm_reg, {COEF_FRAC_BITS{1'b0}}};
    assign nys = {nym_reg, {COEF_FRAC_BITS{1'b0}}};
    assign dsh = CW'({dmag_reg, {QW{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            divx_reg.rem  <= {{(DW-(NW-QW)){1'b0}}, nxs[NW-1:QW]};
            divx_reg.nlow <= nxs[QW-1:0];
            divx_reg.quo  <= '0;
            divx_reg.neg  <= negx_reg;
            divx_reg.ovf  <= (CW'(nxs) >= dsh);
            divy_reg.rem  <= {{(DW-(NW-QW)){1'b0}}, nys[NW-1:QW]};
            divy_reg.nlow <= nys[QW-1:0];
            divy_reg.quo  <= '0;
            divy_reg.neg  <= negy_reg;
            divy_reg.ovf  <= (CW'(nys) >= dsh);
            dmag6_reg     <= dmag_reg;
            dz6_reg       <= dz5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign div_x     = divx_reg;
    assign div_y     = divy_reg;
    assign dmag      = dmag6_reg;
    assign det_zero  = dz6_reg;

endmodule

### design/itgp_div_step.sv
// itgp_div_step: one registered restoring-division step, one quotient bit.
// Depends on itgp_pkg.
module itgp_div_step (
    input  logic                    aclk,
    input  logic                    en,
    input  itgp_pkg::div_t          step_in,
    input  logic [itgp_pkg::DW-1:0] dmag,
    output itgp_pkg::div_t          step_out
);

    localparam int DW = itgp_pkg::DW;
    localparam int QW = itgp_pkg::QW;

    itgp_pkg::div_t step_reg;
    itgp_pkg::div_t step_next;
    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           ge;

    always_comb begin
        shifted   = {step_in.rem, step_in.nlow[QW-1]};
        diff      = shifted - {1'b0, dmag};
        ge        = (shifted >= {1'b0, dmag});
        step_next      = step_in;
        step_next.rem  = ge ? diff[DW-1:0] : shifted[DW-1:0];
        step_next.nlow = {step_in.nlow[QW-2:0], 1'b0};
        step_next.quo  = {step_in.quo[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            step_reg <= step_next;
        end
    end

    assign step_out = step_reg;

endmodule

### design/image_to_ground_plane.sv
// image_to_ground_plane: top level, APB register file, divider pipeline and
// output register. Depends on itgp_pkg, itgp_front and itgp_div_step.
//
// Usage: program the five matrix registers over APB (row0_xy at 0x00,
// row1_xy 0x08, row2_xy 0x10, offsets_01 0x18, offset_2 0x20; 64-bit
// data, pready tied high), then stream pixel requests (s_pixel_u,
// s_pixel_v, Q12.4) on the s_ valid/ready channel. Each pixel yields one
// result request on the m_ channel: ground_forward and ground_left in
// Q16.16 plus solution_valid.
// The pipeline has 39 register stages: six front stages (entries, split
// products, product sums, differences, magnitudes, overflow/seed), 32
// restoring division steps (one quotient bit each, both coordinates in
// parallel), and the output register. Throughput is one pixel per cycle
// while the pipeline is not held; the 32-stage divider chain is most of
// its depth. The whole pipeline advances together; when the receiver holds
// m_ready low with a result waiting, s_ready drops and every stage holds.
// Reset clears all valid bits and the matrix registers to zero; no
// clearing pass is needed.
module image_to_ground_plane #(
    parameter int COEF_FRAC_BITS  = 16,
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // pixel requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_pixel_u,
    input  logic [15:0]        s_pixel_v,
    // ground results
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_ground_forward,
    output logic signed [31:0] m_ground_left,
    output logic               m_solution_valid
);

    localparam int DW    = itgp_pkg::DW;
    localparam int STEPS = itgp_pkg::QW;

    // ---------------- register file ----------------
    logic [63:0] row0_reg, row1_reg, row2_reg, off01_reg;
    logic [31:0] off2_reg;
    logic [2:0]  widx;
    logic        wr;

    assign pready = 1'b1;
    assign widx   = paddr[5:3];
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg  <= '0;
            row1_reg  <= '0;
            row2_reg  <= '0;
            off01_reg <= '0;
            off2_reg  <= '0;
        end else if (wr) begin
            case (widx)
                itgp_pkg::REG_ROW0_XY:    row0_reg  <= pwdata;
                itgp_pkg::REG_ROW1_XY:    row1_reg  <= pwdata;
                itgp_pkg::REG_ROW2_XY:    row2_reg  <= pwdata;
                itgp_pkg::REG_OFFSETS_01: off01_reg <= pwdata;
                itgp_pkg::REG_OFFSET_2:   off2_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            itgp_pkg::REG_ROW0_XY:    prdata = row0_reg;
            itgp_pkg::REG_ROW1_XY:    prdata = row1_reg;
            itgp_pkg::REG_ROW2_XY:    prdata = row2_reg;
            itgp_pkg::REG_OFFSETS_01: prdata = off01_reg;
            itgp_pkg::REG_OFFSET_2:   prdata = {32'd0, off2_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // global advance: the output register is empty or being drained
    logic m_valid_reg;
    logic en;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- front end ----------------
    itgp_pkg::div_t divx_w [0:STEPS];
    itgp_pkg::div_t divy_w [0:STEPS];
    logic [DW-1:0]  dmag_w [0:STEPS];
    logic           dz_w   [0:STEPS];
    logic           vld_w  [0:STEPS];

    itgp_front #(
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pixel_u   (s_pixel_u),
        .pixel_v   (s_pixel_v),
        .m00       ($signed(row0_reg[63:32])),
        .m01       ($signed(row0_reg[31:0])),
        .m03       ($signed(off01_reg[63:32])),
        .m10       ($signed(row1_reg[63:32])),
        .m11       ($signed(row1_reg[31:0])),
        .m13       ($signed(off01_reg[31:0])),
        .m20       ($signed(row2_reg[63:32])),
        .m21       ($signed(row2_reg[31:0])),
        .m23       ($signed(off2_reg)),
        .out_valid (vld_w[0]),
        .div_x     (divx_w[0]),
        .div_y     (divy_w[0]),
        .dmag      (dmag_w[0]),
        .det_zero  (dz_w[0])
    );

    // ---------------- divider chain ----------------
    // one quotient bit per stage for both coordinates; divisor, zero flag
    // and valid ride alongside
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DW-1:0] dmag_reg;
        logic          dz_reg;
        logic          vld_reg;

        itgp_div_step u_x (
            .aclk     (aclk),
            .en       (en),
            .step_in  (divx_w[k]),
            .dmag     (dmag_w[k]),
            .step_out (divx_w[k+1])
        );

        itgp_div_step u_y (
            .aclk     (aclk),
            .en       (en),
            .step_in  (divy_w[k]),
            .dmag     (dmag_w[k]),
            .step_out (divy_w[k+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                dmag_reg <= dmag_w[k];
                dz_reg   <= dz_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_w[k];
            end
        end

        assign dmag_w[k+1] = dmag_reg;
        assign dz_w[k+1]   = dz_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    // ---------------- output register ----------------
    itgp_pkg::quo_t qx, qy;
    logic [31:0]    fwd_reg, left_reg;
    logic           sol_reg;

    assign qx = itgp_pkg::finish_quo(divx_w[STEPS]);
    assign qy = itgp_pkg::finish_quo(divy_w[STEPS]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_w[STEPS];
        end
    end

    // zero determinant forces both coordinates and the flag to zero
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dz_w[STEPS]) begin
                fwd_reg  <= '0;
                left_reg <= '0;
                sol_reg  <= 1'b0;
            end else begin
                fwd_reg  <= qx.value;
                left_reg <= qy.value;
                sol_reg  <= !(qx.sat || qy.sat);
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ground_forward = $signed(fwd_reg);
    assign m_ground_left    = $signed(left_reg);
    assign m_solution_valid = sol_reg;

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for image_to_ground_plane.
// Depends on itgp_pkg (register indexes) and the image_to_ground_plane RTL.
`timescale 1ns / 100ps

// Holds the matrix copy, predicts each pixel's ground point, checks results.
class ground_scoreboard;
    typedef struct {
        logic signed [31:0] fwd;
        logic signed [31:0] left;
        logic               ok;
    } ground_pt_t;

    logic [63:0] row0, row1, row2, off01;
    logic [31:0] off2;
    ground_pt_t  pending[$];
    int          errors;

    function new();
        row0 = '0; row1 = '0; row2 = '0; off01 = '0; off2 = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            itgp_pkg::REG_ROW0_XY:    row0  = val;
            itgp_pkg::REG_ROW1_XY:    row1  = val;
            itgp_pkg::REG_ROW2_XY:    row2  = val;
            itgp_pkg::REG_OFFSETS_01: off01 = val;
            itgp_pkg::REG_OFFSET_2:   off2  = val[31:0];
            default: ;
        endcase
    endfunction

    // truncating quotient with int32 saturation
    function automatic logic [31:0] sat_div(logic signed [129:0] n,
                                            logic signed [129:0] d, ref logic sat);
        logic signed [129:0] q;
        q = n / d;
        if (q > 130'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (q < -130'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function void note_pixel(logic [15:0] pu, logic [15:0] pv);
        logic signed [63:0]  u, v, m00, m01, m10, m11, m20, m21, m03, m13, m23;
        logic signed [129:0] a11, a12, b1, a21, a22, b2, det, nx, ny;
        ground_pt_t          e;
        logic                sat;
        u = {48'd0, pu};
        v = {48'd0, pv};
        m00 = $signed(row0[63:32]);  m01 = $signed(row0[31:0]);
        m10 = $signed(row1[63:32]);  m11 = $signed(row1[31:0]);
        m20 = $signed(row2[63:32]);  m21 = $signed(row2[31:0]);
        m03 = $signed(off01[63:32]); m13 = $signed(off01[31:0]);
        m23 = $signed(off2);
        // pixel has 4 fraction bits, so coefficient-only terms scale by 16
        a11 = u * m20 - (m00 <<< 4);
        a12 = u * m21 - (m01 <<< 4);
        b1  = (m03 <<< 4) - u * m23;
        a21 = v * m20 - (m10 <<< 4);
        a22 = v * m21 - (m11 <<< 4);
        b2  = (m13 <<< 4) - v * m23;
        det = a11 * a22 - a12 * a21;
        nx  = (b1 * a22 - a12 * b2) <<< 16;
        ny  = (a11 * b2 - b1 * a21) <<< 16;
        sat = 1'b0;
        if (det == 0) begin
            e.fwd = '0; e.left = '0; e.ok = 1'b0;
        end else begin
            e.fwd  = sat_div(nx, det, sat);
            e.left = sat_div(ny, det, sat);
            e.ok   = !sat;
        end
        pending = {pending, e};
    endfunction

    function void check_ground(logic [31:0] fwd, logic [31:0] left, logic ok);
        ground_pt_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result fwd=%h left=%h ok=%b", $time, fwd, left, ok);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (fwd !== e.fwd) begin
            $display("%0t: forward expected %h actual %h", $time, e.fwd, fwd);
            errors++;
        end
        if (left !== e.left) begin
            $display("%0t: left expected %h actual %h", $time, e.left, left);
            errors++;
        end
        if (ok !== e.ok) begin
            $display("%0t: solution_valid expected %b actual %b", $time, e.ok, ok);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_pixel_u = '0, s_pixel_v = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_ground_forward, m_ground_left;
    logic               m_solution_valid;

    ground_scoreboard sb = new();
    bit               quiet;  // no gaps or stalls while set

    image_to_ground_plane dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // 64-bit registers sit at 8*index
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // drain the pipeline before touching the matrix
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                               logic [63:0] o01, logic [31:0] o2);
        wait_drained();
        write_reg(itgp_pkg::REG_ROW0_XY, r0);
        write_reg(itgp_pkg::REG_ROW1_XY, r1);
        write_reg(itgp_pkg::REG_ROW2_XY, r2);
        write_reg(itgp_pkg::REG_OFFSETS_01, o01);
        write_reg(itgp_pkg::REG_OFFSET_2, {32'd0, o2});
    endtask

    // s_valid is only lowered when a gap follows, so it never toggles within a step
    task automatic send_pixel(logic [15:0] u, logic [15:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pixel_u <= u;
        s_pixel_v <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(u, v);
    endtask

    function automatic logic [31:0] rand_coef();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    task automatic corner_pixels();
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
    endtask

    task automatic random_pixels(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_pixel(16'($urandom), 16'($urandom));
            else
                send_pixel(16'($urandom_range(0, 16'h2800)),
                           16'($urandom_range(0, 16'h1E00)));
        end
    endtask

    // result side: random stall per request, m_ready lowered only for a stall
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_ground(m_ground_forward, m_ground_left, m_solution_valid);
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers still zero: determinant is zero everywhere
        corner_pixels();

        // every coefficient -1
        load_matrix('1, '1, '1, '1, '1);
        corner_pixels();
        random_pixels(10);

        // most-positive / most-negative coefficients
        load_matrix({32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF},
                    {32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF},
                    32'h8000_0000);
        corner_pixels();

        // no perspective row: plain affine solve
        load_matrix({32'h0001_0000, 32'h0000_4000}, {32'hFFFF_8000, 32'h0002_0000},
                    64'd0, {32'h0012_3456, 32'hFFF0_0000}, 32'h0000_0000);
        corner_pixels();

        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph % 3 == 2);
            load_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                        {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                        rand_coef());
            corner_pixels();
            random_pixels(60);
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule

### files.f
design/itgp_pkg.sv
design/itgp_front.sv
design/itgp_div_step.sv
design/image_to_ground_plane.sv
sim/tb_top.sv
